// ===== sv/fwhb_pkg.sv =====
// shared types, codes and constants of the fixed width histogram binner
// no dependencies; used by fwhb_serdiv, the top level and the checker
package fwhb_pkg;

    localparam int DATA_W       = 32;
    localparam int OP_W         = 3;
    localparam int STATUS_W     = 3;
    localparam int BIN_IDX_W    = 10;
    localparam int BINS_W       = 11;
    localparam int DELTA_W      = 16;
    localparam int MON_W        = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int NUM_BINS_DEF = 1024;

    // serial arithmetic: offset and span are one bit wider than a sample
    localparam int T_W    = DATA_W + 1;
    localparam int P_W    = T_W + BINS_W;
    localparam int STEP_W = $clog2(BINS_W);

    localparam logic [DATA_W-1:0] CNT_MAX    = '1;
    localparam logic [MON_W-1:0]  MON_MAX    = '1;
    localparam logic [BINS_W-1:0] BINS_RESET = BINS_W'(1024);

    localparam logic [OP_W-1:0] OP_SAMPLE = 3'd0;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd1;
    localparam logic [OP_W-1:0] OP_START  = 3'd2;
    localparam logic [OP_W-1:0] OP_STOP   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_COUNTED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LIMITS    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_COLL  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CMD_DONE  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DELTA = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] sample;
        logic [BIN_IDX_W-1:0]     read_index;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [BIN_IDX_W-1:0] bin_index;
        logic [DATA_W-1:0]    bin_count;
        logic                 post_event;
        logic                 collecting;
    } t_out;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_ARITH,
        S_LOOK,
        S_UPD,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        D_IDLE,
        D_MUL,
        D_BIAS,
        D_DIV
    } t_div_state;

endpackage

// ===== sv/fwhb_ram.sv =====
// generic single port ram with registered read
// no dependencies
module fwhb_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic             i_re,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/fwhb_serdiv.sv =====
// serial bin number unit: ceil(t * n / d), one multiplier bit then one quotient bit per cycle
// depends on fwhb_pkg
module fwhb_serdiv (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [fwhb_pkg::T_W-1:0]          i_t,
    input  logic [fwhb_pkg::T_W-1:0]          i_d,
    input  logic [fwhb_pkg::BINS_W-1:0]       i_n,
    output logic                              o_done,
    output logic [fwhb_pkg::BINS_W-1:0]       o_quot
);

    localparam int T_W    = fwhb_pkg::T_W;
    localparam int P_W    = fwhb_pkg::P_W;
    localparam int N_W    = fwhb_pkg::BINS_W;
    localparam int STEP_W = fwhb_pkg::STEP_W;

    fwhb_pkg::t_div_state r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_done, n_done;
    logic [T_W-1:0]    r_t, n_t;
    logic [T_W-1:0]    r_d, n_d;
    logic [N_W-1:0]    r_n, n_n;
    logic [P_W-1:0]    r_acc, n_acc;
    logic [P_W-1:0]    r_dsh, n_dsh;
    logic [N_W-1:0]    r_quot, n_quot;
    logic              fits;

    assign fits = (r_acc >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fwhb_pkg::D_IDLE;
            r_step  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t    <= n_t;
        r_d    <= n_d;
        r_n    <= n_n;
        r_acc  <= n_acc;
        r_dsh  <= n_dsh;
        r_quot <= n_quot;
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_done  = 1'b0;
        n_t     = r_t;
        n_d     = r_d;
        n_n     = r_n;
        n_acc   = r_acc;
        n_dsh   = r_dsh;
        n_quot  = r_quot;
        case (r_state)
            fwhb_pkg::D_IDLE: begin
                if (i_start) begin
                    n_t     = i_t;
                    n_d     = i_d;
                    n_n     = i_n;
                    n_acc   = '0;
                    n_step  = STEP_W'(N_W - 1);
                    n_state = fwhb_pkg::D_MUL;
                end
            end
            fwhb_pkg::D_MUL: begin
                // msb first shift and add over the bits of n
                n_acc = {r_acc[P_W-2:0], 1'b0} + (r_n[r_step] ? P_W'(r_t) : '0);
                if (r_step == '0) begin
                    n_state = fwhb_pkg::D_BIAS;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            fwhb_pkg::D_BIAS: begin
                // + d - 1 turns the floor quotient into a ceiling
                n_acc   = r_acc + P_W'(r_d) - P_W'(1);
                n_dsh   = P_W'(r_d) << (N_W - 1);
                n_quot  = '0;
                n_step  = STEP_W'(N_W - 1);
                n_state = fwhb_pkg::D_DIV;
            end
            fwhb_pkg::D_DIV: begin
                // restoring division, quotient is below 2^N_W
                if (fits) begin
                    n_acc = r_acc - r_dsh;
                end
                n_quot = {r_quot[N_W-2:0], fits};
                n_dsh  = r_dsh >> 1;
                if (r_step == '0) begin
                    n_done  = 1'b1;
                    n_state = fwhb_pkg::D_IDLE;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            default: begin
                n_state = fwhb_pkg::D_IDLE;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== sv/fixed_width_histogram_binner_top.sv =====
// top level of the fixed width histogram binner: control, registers, bin store
// depends on fwhb_pkg, fwhb_ram, fwhb_serdiv

// For an accepted sample the serial arithmetic unit forms the product offset *
// bins (one multiplier bit a cycle), adds the rounding bias and divides (one
// quotient bit a cycle), then the bin store does a read and a write on its
// single port. Rejected samples, start and stop go straight to the result,
// and a bin read within the store reads the store first. A clear command, and
// every write of lower_limit, upper_limit or bins_in_use, sweeps every bin of
// the store, one bin a cycle; the same pass runs after reset. Input is stalled
// during a sweep, configuration writes are always taken. The next beat is
// accepted while a finished result still waits.
module fixed_width_histogram_binner_top #(
    parameter int NUM_BINS = fwhb_pkg::NUM_BINS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  fwhb_pkg::t_in                     i_in,
    output logic                              o_valid,
    input  logic                              i_stall,
    output fwhb_pkg::t_out                    o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fwhb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fwhb_pkg::DATA_W-1:0]       i_cfg_data
);

    localparam int DATA_W  = fwhb_pkg::DATA_W;
    localparam int T_W     = fwhb_pkg::T_W;
    localparam int BINS_W  = fwhb_pkg::BINS_W;
    localparam int BIDX_W  = fwhb_pkg::BIN_IDX_W;
    localparam int MON_W   = fwhb_pkg::MON_W;
    localparam int DELTA_W = fwhb_pkg::DELTA_W;
    localparam int IDX_W   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam logic [16:0]      NB17     = 17'(NUM_BINS);
    localparam logic [IDX_W-1:0] LAST_BIN = IDX_W'(NUM_BINS - 1);

    fwhb_pkg::t_state r_state, n_state;
    logic                       r_collect, n_collect;
    logic signed [DATA_W-1:0]   r_lower, n_lower;
    logic signed [DATA_W-1:0]   r_upper, n_upper;
    logic [BINS_W-1:0]          r_bins, n_bins;
    logic signed [DELTA_W-1:0]  r_delta, n_delta;
    logic [MON_W-1:0]           r_mon, n_mon;
    logic [IDX_W-1:0]           r_addr, n_addr;
    logic                       r_sweep_cmd, n_sweep_cmd;
    logic                       r_out_valid, n_out_valid;

    logic [fwhb_pkg::OP_W-1:0]     r_op, n_op;
    logic [fwhb_pkg::STATUS_W-1:0] r_status, n_status;
    logic [BIDX_W-1:0]             r_bidx, n_bidx;
    logic [DATA_W-1:0]             r_cnt, n_cnt;
    fwhb_pkg::t_out                r_out, n_out;

    logic                cfg_clear;
    logic                accept;
    logic                out_free;
    logic [BINS_W-1:0]   bins_min1;
    logic [BINS_W-1:0]   n_eff;
    logic [T_W-1:0]      offs;
    logic [T_W-1:0]      span;
    logic                div_start;
    logic                div_done;
    logic [BINS_W-1:0]   div_quot;
    logic [BINS_W-1:0]   quot_min1;
    logic [BINS_W-1:0]   bin_num;
    logic [BINS_W-1:0]   bin_sel;
    logic [MON_W-1:0]    mon_clear;
    logic [MON_W-1:0]    mon_inc;
    logic                mon_event;
    logic                ram_we;
    logic                ram_re;
    logic [DATA_W-1:0]   ram_wdata;
    logic [DATA_W-1:0]   ram_rdata;

    assign cfg_clear = i_cfg_valid && (i_cfg_index == fwhb_pkg::CFG_LOWER ||
                       i_cfg_index == fwhb_pkg::CFG_UPPER ||
                       i_cfg_index == fwhb_pkg::CFG_BINS);
    assign o_stall     = (r_state != fwhb_pkg::S_IDLE) || cfg_clear;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && !o_stall;
    assign out_free    = !r_out_valid || !i_stall;

    // zero bins act as one, more than the store holds act as the store size
    assign bins_min1 = (r_bins == '0) ? BINS_W'(1) : r_bins;
    assign n_eff     = ({6'b0, bins_min1} > NB17) ? NB17[BINS_W-1:0] : bins_min1;

    assign offs = {i_in.sample[DATA_W-1], i_in.sample} - {r_lower[DATA_W-1], r_lower};
    assign span = {r_upper[DATA_W-1], r_upper} - {r_lower[DATA_W-1], r_lower};

    assign quot_min1 = (div_quot == '0) ? BINS_W'(1) : div_quot;
    assign bin_num   = (quot_min1 > n_eff) ? n_eff : quot_min1;
    assign bin_sel   = bin_num - BINS_W'(1);

    assign mon_clear = r_delta[DELTA_W-1] ? '0 : r_delta[MON_W-1:0] + MON_W'(1);
    assign mon_inc   = (r_status == fwhb_pkg::ST_COUNTED && r_mon != fwhb_pkg::MON_MAX) ?
                       r_mon + MON_W'(1) : r_mon;
    assign mon_event = r_delta[DELTA_W-1] || (mon_inc > r_delta[MON_W-1:0]);

    fwhb_serdiv u_serdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_t     (offs),
        .i_d     (span),
        .i_n     (n_eff),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    fwhb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_BINS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (r_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fwhb_pkg::S_SWEEP;
            r_collect   <= 1'b1;
            r_lower     <= '0;
            r_upper     <= '0;
            r_bins      <= fwhb_pkg::BINS_RESET;
            r_delta     <= '0;
            r_mon       <= '0;
            r_addr      <= '0;
            r_sweep_cmd <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_collect   <= n_collect;
            r_lower     <= n_lower;
            r_upper     <= n_upper;
            r_bins      <= n_bins;
            r_delta     <= n_delta;
            r_mon       <= n_mon;
            r_addr      <= n_addr;
            r_sweep_cmd <= n_sweep_cmd;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_status <= n_status;
        r_bidx   <= n_bidx;
        r_cnt    <= n_cnt;
        r_out    <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_collect   = r_collect;
        n_lower     = r_lower;
        n_upper     = r_upper;
        n_bins      = r_bins;
        n_delta     = r_delta;
        n_mon       = r_mon;
        n_addr      = r_addr;
        n_sweep_cmd = r_sweep_cmd;
        n_out_valid = r_out_valid;
        n_op        = r_op;
        n_status    = r_status;
        n_bidx      = r_bidx;
        n_cnt       = r_cnt;
        n_out       = r_out;
        div_start   = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_wdata   = '0;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            fwhb_pkg::S_SWEEP: begin
                ram_we = 1'b1;
                if (r_addr == LAST_BIN) begin
                    n_state = r_sweep_cmd ? fwhb_pkg::S_DONE : fwhb_pkg::S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            fwhb_pkg::S_IDLE: begin
                if (accept) begin
                    n_op     = i_in.op;
                    n_bidx   = '0;
                    n_cnt    = '0;
                    n_status = fwhb_pkg::ST_CMD_DONE;
                    n_state  = fwhb_pkg::S_DONE;
                    case (i_in.op)
                        fwhb_pkg::OP_SAMPLE: begin
                            if (!r_collect) begin
                                n_status = fwhb_pkg::ST_NOT_COLL;
                            end else if (r_lower >= r_upper) begin
                                n_status = fwhb_pkg::ST_LIMITS;
                            end else if (i_in.sample < r_lower || i_in.sample >= r_upper) begin
                                n_status = fwhb_pkg::ST_RANGE;
                            end else begin
                                n_status  = fwhb_pkg::ST_COUNTED;
                                div_start = 1'b1;
                                n_state   = fwhb_pkg::S_ARITH;
                            end
                        end
                        fwhb_pkg::OP_CLEAR: begin
                            n_mon       = mon_clear;
                            n_addr      = '0;
                            n_sweep_cmd = 1'b1;
                            n_state     = fwhb_pkg::S_SWEEP;
                        end
                        fwhb_pkg::OP_START: begin
                            n_collect = 1'b1;
                        end
                        fwhb_pkg::OP_STOP: begin
                            n_collect = 1'b0;
                        end
                        fwhb_pkg::OP_READ: begin
                            n_bidx = i_in.read_index;
                            if ({7'b0, i_in.read_index} < NB17) begin
                                n_addr  = IDX_W'(i_in.read_index);
                                n_state = fwhb_pkg::S_LOOK;
                            end
                        end
                        default: begin
                            n_state = fwhb_pkg::S_DONE;
                        end
                    endcase
                end
            end
            fwhb_pkg::S_ARITH: begin
                if (div_done) begin
                    n_addr  = IDX_W'(bin_sel);
                    n_bidx  = bin_sel[BIDX_W-1:0];
                    n_state = fwhb_pkg::S_LOOK;
                end
            end
            fwhb_pkg::S_LOOK: begin
                ram_re  = 1'b1;
                n_state = fwhb_pkg::S_UPD;
            end
            fwhb_pkg::S_UPD: begin
                if (r_op == fwhb_pkg::OP_SAMPLE) begin
                    // a full count wraps to zero and is then incremented
                    ram_wdata = (ram_rdata == fwhb_pkg::CNT_MAX) ?
                                DATA_W'(1) : ram_rdata + DATA_W'(1);
                    ram_we    = 1'b1;
                    n_cnt     = ram_wdata;
                end else begin
                    n_cnt = ram_rdata;
                end
                n_state = fwhb_pkg::S_DONE;
            end
            fwhb_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.status     = r_status;
                    n_out.bin_index  = r_bidx;
                    n_out.bin_count  = r_cnt;
                    n_out.post_event = 1'b0;
                    n_out.collecting = r_collect;
                    if (r_op == fwhb_pkg::OP_SAMPLE) begin
                        n_out.post_event = mon_event;
                        n_mon            = mon_event ? '0 : mon_inc;
                    end
                    n_state = fwhb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fwhb_pkg::S_IDLE;
            end
        endcase

        if (i_cfg_valid) begin
            case (i_cfg_index)
                fwhb_pkg::CFG_LOWER: n_lower = i_cfg_data;
                fwhb_pkg::CFG_UPPER: n_upper = i_cfg_data;
                fwhb_pkg::CFG_BINS:  n_bins  = i_cfg_data[BINS_W-1:0];
                fwhb_pkg::CFG_DELTA: n_delta = i_cfg_data[DELTA_W-1:0];
                default: ;
            endcase
            // bin layout changed: wipe the store
            if (cfg_clear) begin
                n_mon       = mon_clear;
                n_addr      = '0;
                n_sweep_cmd = (r_state == fwhb_pkg::S_SWEEP) ? r_sweep_cmd : 1'b0;
                n_state     = fwhb_pkg::S_SWEEP;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

endmodule

// ===== sv/fwhb_checker.sv =====
// port level checks of the fixed width histogram binner, bound to its top level
// depends on fwhb_pkg and fixed_width_histogram_binner_top
module fwhb_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_valid,
    input logic                           i_stall,
    input fwhb_pkg::t_out                 o_out
);

    // a command beat never flags an event
    a_cmd_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.status == fwhb_pkg::ST_CMD_DONE |-> !o_out.post_event)
        else $error("command beat flagged an event");

    // an uncounted sample reports no bin
    a_reject_no_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out.status == fwhb_pkg::ST_RANGE ||
                    o_out.status == fwhb_pkg::ST_LIMITS ||
                    o_out.status == fwhb_pkg::ST_NOT_COLL)
        |-> o_out.bin_index == '0 && o_out.bin_count == '0)
        else $error("rejected sample carries a bin");

    // a counted bin reads at least one after its increment
    a_counted_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.status == fwhb_pkg::ST_COUNTED |-> o_out.bin_count != '0)
        else $error("counted bin reads zero");

    // a sample refused for collection off shows collection off
    a_not_coll_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.status == fwhb_pkg::ST_NOT_COLL |-> !o_out.collecting)
        else $error("not collecting status with collection on");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out))
        else $error("stalled result beat changed");

endmodule

bind fixed_width_histogram_binner_top fwhb_checker u_fwhb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_out   (o_out)
);
